// ===== src/q2e_pkg.sv =====
// Shared types and constants for the quaternion to Euler angle converter.
// Used by q2e_atan2 and quaternion_to_euler; depends on nothing else.
`default_nettype none

package q2e_pkg;

  // Magnitudes of the atan2 operands, wide enough for any product sum.
  localparam int MagW        = 64;
  // CORDIC vectoring steps and the widths of its x/y and angle registers.
  localparam int CordicSteps = 31;
  localparam int CordicXyW   = 34;
  localparam int CordicThW   = 33;
  // Internal binary angle: pi equals 2^31.
  localparam int AngW        = 32;

  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
  } smag_t;

  // atan(2^-i) with pi = 2^31.
  function automatic logic [29:0] atan_entry(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'h20000000;
      5'd1:    v = 30'h12E4051E;
      5'd2:    v = 30'h09FB385B;
      5'd3:    v = 30'h051111D4;
      5'd4:    v = 30'h028B0D43;
      5'd5:    v = 30'h0145D7E1;
      5'd6:    v = 30'h00A2F61E;
      5'd7:    v = 30'h00517C55;
      5'd8:    v = 30'h0028BE53;
      5'd9:    v = 30'h00145F2F;
      5'd10:   v = 30'h000A2F98;
      5'd11:   v = 30'h000517CC;
      5'd12:   v = 30'h00028BE6;
      5'd13:   v = 30'h000145F3;
      5'd14:   v = 30'h0000A2FA;
      5'd15:   v = 30'h0000517D;
      5'd16:   v = 30'h000028BE;
      5'd17:   v = 30'h0000145F;
      5'd18:   v = 30'h00000A30;
      5'd19:   v = 30'h00000518;
      5'd20:   v = 30'h0000028C;
      5'd21:   v = 30'h00000146;
      5'd22:   v = 30'h000000A3;
      5'd23:   v = 30'h00000051;
      5'd24:   v = 30'h00000029;
      5'd25:   v = 30'h00000014;
      5'd26:   v = 30'h0000000A;
      5'd27:   v = 30'h00000005;
      5'd28:   v = 30'h00000003;
      5'd29:   v = 30'h00000001;
      5'd30:   v = 30'h00000001;
      default: v = 30'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== src/quaternion_to_euler.sv =====
// Top level of the quaternion to ZYX Euler angle converter: products, sums,
// pitch cosine square root and output stage. Depends on q2e_pkg, q2e_atan2.
`default_nettype none

// Usage
// The slave stream carries one quaternion per transfer (w, x, y, z, each
// signed Q1.(QUAT_WIDTH-1)). The master stream returns roll, pitch and yaw
// as signed binary angles where pi is 2^(ANGLE_WIDTH-1); tuser carries the
// pitch saturation flag, set when |2(wy-zx)| reaches one and pitch is held
// at plus or minus pi/2.
// The datapath is a single pipeline of 80 register stages: products, sums,
// 34 stages for the pitch cosine (square and a one-bit-per-stage square
// root, roll and yaw operands wait in a matching delay line), then three
// parallel atan2 units of 43 stages each (11 normalization stages and 31
// CORDIC steps plus quadrant restore), then the output register.
// Throughput is one quaternion per cycle while the receiver takes results.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready_o drops; nothing is lost or repeated. Reset clears all
// valid bits, so the pipeline comes up empty. No state is kept between
// items.
module quaternion_to_euler import q2e_pkg::*; #(
  parameter int QUAT_WIDTH  = 16,
  parameter int ANGLE_WIDTH = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // quat_w, quat_x, quat_y, quat_z from the lowest bit up, zero padded.
  input  wire logic [((4*QUAT_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // roll_angle, pitch_angle, yaw_angle from the lowest bit up, zero padded.
  output logic [((3*ANGLE_WIDTH+7)/8)*8-1:0]     m_axis_tdata_o,
  // pitch_clamped.
  output logic                                   m_axis_tuser_o
);

  localparam int QW       = QUAT_WIDTH;
  localparam int AW       = ANGLE_WIDTH;
  localparam int PW       = 2 * QW;
  localparam int SW       = 2 * QW + 2;
  localparam int OUT_DW   = ((3 * AW + 7) / 8) * 8;
  localparam int TSR      = (QW >= 16) ? (2 * QW - 32) : 0;
  localparam int TSL      = (QW >= 16) ? 0 : (32 - 2 * QW);
  localparam int SqrtSteps = 31;
  localparam int RootW    = 61;
  localparam int DLY      = 3 + SqrtSteps;
  localparam int ASH      = AngW - AW;
  localparam logic [AngW-1:0] RND = (ASH == 0) ? '0 : (AngW'(1) << ((ASH > 0) ? ASH - 1 : 0));
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (2 * QW - 3);

  typedef struct packed {
    smag_t rs;
    smag_t rc;
    smag_t ys;
    smag_t yc;
  } ry_t;

  // Pitch operand while the cosine is computed.
  typedef struct packed {
    logic        clamp;
    logic        dneg;
    logic        sneg;
    logic [29:0] tq;
  } ptag_t;

  function automatic smag_t to_smag(input logic signed [SW-1:0] v);
    smag_t            r;
    logic [SW-1:0] a;
    a     = v[SW-1] ? SW'(-v) : SW'(v);
    r.neg = v[SW-1];
    r.mag = MagW'(a);
    return r;
  endfunction

  logic adv;
  logic out_v_q;

  assign adv             = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // Stage 1: all nine products.
  logic signed [QW-1:0] qw, qx, qy, qz;
  logic                 v1_q;
  logic signed [PW-1:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;

  assign qw = signed'(s_axis_tdata_i[QW-1:0]);
  assign qx = signed'(s_axis_tdata_i[2*QW-1:QW]);
  assign qy = signed'(s_axis_tdata_i[3*QW-1:2*QW]);
  assign qz = signed'(s_axis_tdata_i[4*QW-1:3*QW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wx_q <= qw * qx;
      yz_q <= qy * qz;
      xx_q <= qx * qx;
      yy_q <= qy * qy;
      wy_q <= qw * qy;
      zx_q <= qz * qx;
      wz_q <= qw * qz;
      xy_q <= qx * qy;
      zz_q <= qz * qz;
    end
  end

  // Stage 2: the five sums, as sign and magnitude.
  logic signed [SW-1:0] roll_s, roll_c, yaw_s, yaw_c, dsum;
  smag_t                d_sm;
  logic                 v2_q;
  ry_t                  ry2_q;
  logic                 dneg2_q, clamp2_q;
  logic [MagW-1:0]      dmag2_q;

  always_comb begin
    roll_s = SW'(wx_q) + SW'(yz_q);
    roll_c = HALF - SW'(xx_q) - SW'(yy_q);
    yaw_s  = SW'(wz_q) + SW'(xy_q);
    yaw_c  = HALF - SW'(yy_q) - SW'(zz_q);
    dsum   = SW'(wy_q) - SW'(zx_q);
    d_sm   = to_smag(dsum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ry2_q.rs <= to_smag(roll_s);
      ry2_q.rc <= to_smag(roll_c);
      ry2_q.ys <= to_smag(yaw_s);
      ry2_q.yc <= to_smag(yaw_c);
      dneg2_q  <= d_sm.neg;
      dmag2_q  <= d_sm.mag;
      clamp2_q <= d_sm.mag >= MagW'(HALF);
    end
  end

  // Delay line for roll and yaw operands; its valid bits pace the pitch path.
  logic [DLY-1:0] dv_q;
  ry_t            dl_q [DLY];

  for (genvar k = 0; k < DLY; k++) begin : g_dly
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (adv) begin
        dv_q[k] <= (k == 0) ? v2_q : dv_q[(k == 0) ? 0 : k - 1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dl_q[k] <= (k == 0) ? ry2_q : dl_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // Pitch stage 3: sine term in Q0.30.
  logic [MagW-1:0] t_full;
  logic [29:0]     tq;
  ptag_t           pt3_q, pt4_q, pt5_q;
  logic [59:0]     sq4_q;
  logic [RootW-1:0] n5_q;

  assign t_full = dmag2_q << 1;
  assign tq     = 30'((t_full >> TSR) << TSL);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pt3_q.clamp <= clamp2_q;
      pt3_q.dneg  <= dneg2_q;
      pt3_q.sneg  <= dneg2_q && (tq != '0);
      pt3_q.tq    <= tq;
      // Stage 4: square of the sine term.
      pt4_q       <= pt3_q;
      sq4_q       <= pt3_q.tq * pt3_q.tq;
      // Stage 5: one minus the square.
      pt5_q       <= pt4_q;
      n5_q        <= (RootW'(1) << 60) - RootW'(sq4_q);
    end
  end

  // Square root, one result bit per stage.
  logic [RootW-1:0] sr_q [SqrtSteps];
  logic [RootW-1:0] sn_q [SqrtSteps];
  ptag_t            st_q [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam logic [RootW-1:0] BIT = RootW'(1) << (60 - 2 * k);
    logic [RootW-1:0] rin, nin, trial, r_d, n_d;
    ptag_t            tin;

    if (k == 0) begin : g_src
      always_comb begin
        rin = '0;
        nin = n5_q;
        tin = pt5_q;
      end
    end else begin : g_chain
      always_comb begin
        rin = sr_q[k-1];
        nin = sn_q[k-1];
        tin = st_q[k-1];
      end
    end

    always_comb begin
      trial = rin + BIT;
      if (nin >= trial) begin
        n_d = nin - trial;
        r_d = (rin >> 1) + BIT;
      end else begin
        n_d = nin;
        r_d = rin >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sr_q[k] <= r_d;
        sn_q[k] <= n_d;
        st_q[k] <= tin;
      end
    end
  end

  // Three atan2 units in parallel.
  ptag_t           pt_last;
  smag_t           ps, pc;
  logic            rv, pv, yv;
  logic [AngW-1:0] rang, pang, yang;
  logic [1:0]      pside;

  assign pt_last = st_q[SqrtSteps-1];
  assign ps.neg  = pt_last.sneg;
  assign ps.mag  = MagW'(pt_last.tq);
  assign pc.neg  = 1'b0;
  assign pc.mag  = MagW'(sr_q[SqrtSteps-1][30:0]);

  q2e_atan2 #(.SIDE_W(1)) u_roll (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(dv_q[DLY-1]),
    .s_i    (dl_q[DLY-1].rs),
    .c_i    (dl_q[DLY-1].rc),
    .side_i (1'b0),
    .valid_o(rv),
    .angle_o(rang),
    .side_o ()
  );

  q2e_atan2 #(.SIDE_W(2)) u_pitch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(dv_q[DLY-1]),
    .s_i    (ps),
    .c_i    (pc),
    .side_i ({pt_last.clamp, pt_last.dneg}),
    .valid_o(pv),
    .angle_o(pang),
    .side_o (pside)
  );

  q2e_atan2 #(.SIDE_W(1)) u_yaw (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(dv_q[DLY-1]),
    .s_i    (dl_q[DLY-1].ys),
    .c_i    (dl_q[DLY-1].yc),
    .side_i (1'b0),
    .valid_o(yv),
    .angle_o(yang),
    .side_o ()
  );

  // Output stage: saturated pitch select and rounding to the output width.
  logic [AngW-1:0] pth, rsum, psum, ysum;
  logic [AW-1:0]   roll_q, pitch_q, yaw_q;
  logic            clamp_q;

  always_comb begin
    if (pside[1]) begin
      pth = pside[0] ? (AngW'(0) - (AngW'(1) << 30)) : (AngW'(1) << 30);
    end else begin
      pth = pang;
    end
    rsum = rang + RND;
    psum = pth + RND;
    ysum = yang + RND;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= rv && pv && yv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      roll_q  <= AW'(rsum >> ASH);
      pitch_q <= AW'(psum >> ASH);
      yaw_q   <= AW'(ysum >> ASH);
      clamp_q <= pside[1];
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = OUT_DW'({yaw_q, pitch_q, roll_q});
  assign m_axis_tuser_o  = clamp_q;

endmodule

`default_nettype wire

// ===== src/q2e_atan2.sv =====
// Pipelined full-circle atan2: operand normalization, CORDIC vectoring and
// quadrant restore. Depends on q2e_pkg.
`default_nettype none

module q2e_atan2 import q2e_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire smag_t             s_i,
  input  wire smag_t             c_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [AngW-1:0]        angle_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int NormSteps = 11;

  typedef struct packed {
    logic              sneg;
    logic              cneg;
    logic              zero;
    logic [SIDE_W-1:0] side;
  } tag_t;

  logic [NormSteps-1:0] nv_q;
  logic [MagW-1:0]      nx_q [NormSteps];
  logic [MagW-1:0]      ny_q [NormSteps];
  logic [MagW-1:0]      nm_q [NormSteps];
  tag_t                 nt_q [NormSteps];

  logic [CordicSteps-1:0]       cv_q;
  logic signed [CordicXyW-1:0] cx_q [CordicSteps];
  logic signed [CordicXyW-1:0] cy_q [CordicSteps];
  logic signed [CordicThW-1:0] cth_q [CordicSteps];
  tag_t                         ct_q [CordicSteps];

  // Normalization: one shift step per stage, right shifts first.
  for (genvar j = 0; j < NormSteps; j++) begin : g_norm
    localparam int  SH    = (j < 6) ? (32 >> j) : (16 >> (j - 6));
    localparam bit  RIGHT = (j < 6);
    logic            vin;
    logic [MagW-1:0] xin, yin, min_v, x_d, y_d, m_d;
    tag_t            tin;
    logic            hit;

    if (j == 0) begin : g_src
      always_comb begin
        vin      = valid_i;
        xin      = c_i.mag;
        yin      = s_i.mag;
        min_v    = (c_i.mag > s_i.mag) ? c_i.mag : s_i.mag;
        tin.sneg = s_i.neg;
        tin.cneg = c_i.neg;
        tin.zero = (c_i.mag == '0) && (s_i.mag == '0);
        tin.side = side_i;
      end
    end else begin : g_chain
      always_comb begin
        vin   = nv_q[j-1];
        xin   = nx_q[j-1];
        yin   = ny_q[j-1];
        min_v = nm_q[j-1];
        tin   = nt_q[j-1];
      end
    end

    always_comb begin
      if (RIGHT) begin
        hit = min_v >= (MagW'(1) << (29 + SH));
        x_d = hit ? (xin >> SH) : xin;
        y_d = hit ? (yin >> SH) : yin;
        m_d = hit ? (min_v >> SH) : min_v;
      end else begin
        hit = min_v < (MagW'(1) << (30 - SH));
        x_d = hit ? (xin << SH) : xin;
        y_d = hit ? (yin << SH) : yin;
        m_d = hit ? (min_v << SH) : min_v;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nv_q[j] <= 1'b0;
      end else if (en_i) begin
        nv_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nx_q[j] <= x_d;
        ny_q[j] <= y_d;
        nm_q[j] <= m_d;
        nt_q[j] <= tin;
      end
    end
  end

  // CORDIC vectoring, one micro-rotation per stage.
  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    localparam logic signed [CordicThW-1:0] ANG = signed'(CordicThW'(atan_entry(5'(i))));
    logic                         vin;
    logic signed [CordicXyW-1:0] xin, yin, x_d, y_d;
    logic signed [CordicThW-1:0] thin, th_d;
    tag_t                         tin;

    if (i == 0) begin : g_src
      always_comb begin
        vin  = nv_q[NormSteps-1];
        xin  = signed'({{(CordicXyW-30){1'b0}}, nx_q[NormSteps-1][29:0]});
        yin  = signed'({{(CordicXyW-30){1'b0}}, ny_q[NormSteps-1][29:0]});
        thin = '0;
        tin  = nt_q[NormSteps-1];
      end
    end else begin : g_chain
      always_comb begin
        vin  = cv_q[i-1];
        xin  = cx_q[i-1];
        yin  = cy_q[i-1];
        thin = cth_q[i-1];
        tin  = ct_q[i-1];
      end
    end

    always_comb begin
      if (yin >= 0) begin
        x_d  = xin + (yin >>> i);
        y_d  = yin - (xin >>> i);
        th_d = thin + ANG;
      end else begin
        x_d  = xin - (yin >>> i);
        y_d  = yin + (xin >>> i);
        th_d = thin - ANG;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i] <= 1'b0;
      end else if (en_i) begin
        cv_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cx_q[i]  <= x_d;
        cy_q[i]  <= y_d;
        cth_q[i] <= th_d;
        ct_q[i]  <= tin;
      end
    end
  end

  // Clamp to the first quadrant, then mirror by the operand signs.
  logic signed [CordicThW-1:0] th_last;
  tag_t                        t_last;
  logic [AngW-1:0]             th_clip, th_quad;

  assign th_last = cth_q[CordicSteps-1];
  assign t_last  = ct_q[CordicSteps-1];

  always_comb begin
    if (t_last.zero || th_last < 0) begin
      th_clip = '0;
    end else if (th_last > (CordicThW'(1) <<< 30)) begin
      th_clip = AngW'(1) << 30;
    end else begin
      th_clip = AngW'(th_last);
    end
    th_quad = th_clip;
    if (t_last.cneg) begin
      th_quad = (AngW'(1) << (AngW - 1)) - th_quad;
    end
    if (t_last.sneg) begin
      th_quad = AngW'(0) - th_quad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= cv_q[CordicSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_o <= th_quad;
      side_o  <= t_last.side;
    end
  end

endmodule

`default_nettype wire
